/* src/sqa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sqa_pkg;

    // word and datapath widths
    localparam int DW        = 32;
    localparam int PW        = 2 * DW;
    localparam int FRAC_BITS = 31;
    // quotient bits resolved by the cell row; anything above overflows
    localparam int QBITS     = DW + 1;
    localparam int HBITS     = PW - QBITS;

    localparam logic signed [DW-1:0] VAL_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] VAL_MIN = {1'b1, {(DW-1){1'b0}}};

    // magnitude of the most negative value, in quotient width plus carry
    localparam logic [QBITS:0] MAG_MIN = (QBITS+1)'(1) << (DW-1);

    // half an lsb added ahead of the product shift
    localparam logic signed [PW-1:0] ROUND_HALF = PW'(1) << (FRAC_BITS-1);

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    // data handed from cell to cell
    typedef struct packed {
        logic              is_div;
        logic [DW-1:0]     res;
        logic              neg;
        logic              ovf;
        logic [DW-1:0]     rem;
        logic [DW-1:0]     divisor;
        logic [QBITS-1:0]  dend;
        logic [QBITS-1:0]  quo;
    } cell_t;

endpackage

`default_nettype wire

/* src/sqa_prep.sv */
`timescale 1ns / 1ps
`default_nettype none

module sqa_prep
    import sqa_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [1:0]           opcode,
    input  wire logic signed [DW-1:0] operand_a,
    input  wire logic signed [DW-1:0] operand_b,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output cell_t                     out_data
);

    logic                 a_valid_reg;
    op_t                  op_reg;
    logic signed [DW-1:0] a_reg;
    logic signed [DW-1:0] b_reg;
    logic signed [PW-1:0] prod_reg;
    logic                 b_valid_reg;
    cell_t                data_reg;
    cell_t                data_next;

    logic                 a_ready;
    logic                 b_ready;

    logic signed [DW:0]   sum;
    logic [DW-1:0]        sum_sat;
    logic signed [PW-1:0] prnd;
    logic signed [PW-1:0] psh;
    logic [DW-1:0]        mul_sat;
    logic [PW-DW:0]       p_hi;
    logic [DW-1:0]        a_mag;
    logic [DW-1:0]        b_mag;
    logic [PW-1:0]        na;
    logic [HBITS-1:0]     na_hi;

    // bubble-collapsing ready for the two stages
    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
                a_valid_reg <= in_valid;
            if (b_ready)
                b_valid_reg <= a_valid_reg;
        end
    end

    // stage one: operands and the full product
    always_ff @(posedge clk)
    begin
        if (in_valid && a_ready)
        begin
            op_reg   <= op_t'(opcode);
            a_reg    <= operand_a;
            b_reg    <= operand_b;
            prod_reg <= PW'(operand_a) * PW'(operand_b);
        end
    end

    // add and subtract with saturation
    always_comb
    begin
        if (op_reg == OP_SUB)
            sum = {a_reg[DW-1], a_reg} - {b_reg[DW-1], b_reg};
        else
            sum = {a_reg[DW-1], a_reg} + {b_reg[DW-1], b_reg};
        if (sum[DW] != sum[DW-1])
            sum_sat = sum[DW] ? VAL_MIN : VAL_MAX;
        else
            sum_sat = sum[DW-1:0];
    end

    // product rounding, shift and saturation
    always_comb
    begin
        prnd = prod_reg + ROUND_HALF;
        psh  = prnd >>> FRAC_BITS;
        p_hi = psh[PW-1:DW-1];
        if ((&p_hi) || !(|p_hi))
            mul_sat = psh[DW-1:0];
        else
            mul_sat = psh[PW-1] ? VAL_MIN : VAL_MAX;
    end

    // divide set-up: magnitudes, scaled dividend, early overflow
    always_comb
    begin
        a_mag = a_reg[DW-1] ? DW'(-a_reg) : a_reg;
        b_mag = b_reg[DW-1] ? DW'(-b_reg) : b_reg;
        na    = {{(PW-DW){1'b0}}, a_mag} << FRAC_BITS;
        na_hi = na[PW-1:QBITS];
    end

    always_comb
    begin
        data_next.is_div  = (op_reg == OP_DIV);
        data_next.divisor = b_mag;
        data_next.rem     = {{(DW-HBITS){1'b0}}, na_hi};
        data_next.dend    = na[QBITS-1:0];
        data_next.quo     = '0;
        if (b_mag == '0)
        begin
            data_next.ovf = 1'b1;
            data_next.neg = a_reg[DW-1];
        end
        else
        begin
            data_next.ovf = ({{(DW-HBITS){1'b0}}, na_hi} >= b_mag);
            data_next.neg = a_reg[DW-1] ^ b_reg[DW-1];
        end
        case (op_reg)
            OP_ADD:  data_next.res = sum_sat;
            OP_SUB:  data_next.res = sum_sat;
            OP_MUL:  data_next.res = mul_sat;
            default: data_next.res = '0;
        endcase
    end

    // stage two: initial cell state
    always_ff @(posedge clk)
    begin
        if (a_valid_reg && b_ready)
            data_reg <= data_next;
    end

    assign out_valid = b_valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

/* src/sqa_div_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module sqa_div_cell
    import sqa_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire cell_t in_data,
    output logic       out_valid,
    input  wire logic  out_ready,
    output cell_t      out_data
);

    logic          valid_reg;
    cell_t         data_reg;
    cell_t         data_next;
    logic [DW:0]   rem_sh;
    logic          q_bit;

    assign in_ready = !valid_reg || out_ready;

    // one restoring step: bring down a dividend bit, try the subtract
    always_comb
    begin
        rem_sh    = {in_data.rem, in_data.dend[QBITS-1]};
        q_bit     = (rem_sh >= {1'b0, in_data.divisor});
        data_next = in_data;
        if (q_bit)
            data_next.rem = DW'(rem_sh - {1'b0, in_data.divisor});
        else
            data_next.rem = rem_sh[DW-1:0];
        data_next.dend = {in_data.dend[QBITS-2:0], 1'b0};
        data_next.quo  = {in_data.quo[QBITS-2:0], q_bit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

/* src/sqa_final.sv */
`timescale 1ns / 1ps
`default_nettype none

module sqa_final
    import sqa_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire cell_t         in_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic signed [DW-1:0] result_value
);

    logic                 valid_reg;
    logic signed [DW-1:0] result_reg;
    logic signed [DW-1:0] result_next;
    logic                 rnd;
    logic [QBITS:0]       qr;
    logic [QBITS:0]       qneg;

    assign in_ready = !valid_reg || out_ready;

    // quotient rounding, ties away from zero, then sign and saturation
    always_comb
    begin
        rnd  = ({in_data.rem, 1'b0} >= {1'b0, in_data.divisor});
        qr   = {1'b0, in_data.quo} + (QBITS+1)'(rnd);
        qneg = -qr;
        if (!in_data.is_div)
            result_next = in_data.res;
        else if (in_data.ovf)
            result_next = in_data.neg ? VAL_MIN : VAL_MAX;
        else if (in_data.neg)
            result_next = (qr > MAG_MIN) ? VAL_MIN : qneg[DW-1:0];
        else
            result_next = (qr >= MAG_MIN) ? VAL_MAX : qr[DW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            result_reg <= result_next;
    end

    assign out_valid    = valid_reg;
    assign result_value = result_reg;

endmodule

`default_nettype wire

/* src/saturating_q_format_alu.sv */
`timescale 1ns / 1ps
`default_nettype none

// Saturating Q1.31 ALU: add, subtract, rounded multiply and rounded divide on
// signed 32-bit operands, one result per transfer. A new item can be taken
// every cycle while the output side keeps taking results. Each item passes
// through two set-up stages (operand register with the 32x32 product, then
// add/sub and multiply saturation plus divide set-up), a row of 33 divider
// cells that each resolve one quotient bit, and the output register where
// the quotient is rounded and saturated. All operations run down the same
// row so results leave in order. Stalls on the output side are absorbed
// stage by stage, so the input keeps taking items until the row is full.

module saturating_q_format_alu
    import sqa_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [1:0]           opcode,
    input  wire logic signed [DW-1:0] operand_a,
    input  wire logic signed [DW-1:0] operand_b,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic signed [DW-1:0]      result_value
);

    logic  chain_v   [QBITS+1];
    logic  chain_rdy [QBITS+1];
    cell_t chain_d   [QBITS+1];

    logic  last_v;
    logic  last_rdy;
    cell_t last_d;

    // operand set-up
    sqa_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .out_valid (chain_v[0]),
        .out_ready (chain_rdy[0]),
        .out_data  (chain_d[0])
    );

    // divider cell row
    for (genvar i = 0; i < QBITS; i++)
    begin : g_cell
        sqa_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_v[i]),
            .in_ready  (chain_rdy[i]),
            .in_data   (chain_d[i]),
            .out_valid (chain_v[i+1]),
            .out_ready (chain_rdy[i+1]),
            .out_data  (chain_d[i+1])
        );
    end

    assign last_v          = chain_v[QBITS];
    assign last_d          = chain_d[QBITS];
    assign chain_rdy[QBITS] = last_rdy;

    // rounding and output register
    sqa_final u_final (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (last_v),
        .in_ready     (last_rdy),
        .in_data      (last_d),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_value (result_value)
    );

    // non-divide results pass the row untouched
    a_pass_through: assert property (@(posedge clk) disable iff (!rst_n)
        (last_v && last_rdy && !last_d.is_div) |=> (result_value == $past(last_d.res)))
        else $error("non-divide result altered after the cell row");

    // forced divide overflow saturates to the signed limits
    a_div_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (last_v && last_rdy && last_d.is_div && last_d.ovf) |=>
        (result_value == VAL_MAX || result_value == VAL_MIN))
        else $error("divide overflow did not saturate");

    // an empty output register never holds back the row
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> last_rdy)
        else $error("cell row stalled with an empty output register");

    // a transfer out of the row always lands in the output register
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (last_v && last_rdy) |=> out_valid)
        else $error("result lost between cell row and output");

endmodule

`default_nettype wire
